### sv/lwks_pkg.sv
// Shared types and constants for the LWE key-switching accumulator.
`default_nettype none
package lwks_pkg;
	localparam logic [1:0] OP_TABLE = 2'd0;
	localparam logic [1:0] OP_BODY  = 2'd1;
	localparam logic [1:0] OP_COEFF = 2'd2;

	typedef struct packed {
		logic [1:0]  operation;
		logic [5:0]  coeff_index;
		logic [2:0]  digit_position;
		logic [1:0]  digit_value;
		logic [4:0]  word_index;
		logic [63:0] value;
		logic        last;
	} item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIGIT,
		ST_SUB,
		ST_EMIT
	} back_state_t;
endpackage
`default_nettype wire

### sv/lwks_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module lwks_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

### sv/lwks_fifo.sv
// Short item queue between the front and back parts.
`default_nettype none
module lwks_fifo (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  lwks_pkg::item_t      push_data,
	output logic                 full,
	input  wire                  pop,
	output lwks_pkg::item_t      pop_data,
	output logic                 empty
);
	lwks_pkg::item_t buf_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign empty    = (cnt_q == 2'd0);
	assign pop_data = buf_q[rp_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			buf_q[wp_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full) wp_q <= ~wp_q;
			if (pop && !empty) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
		end
	end
endmodule
`default_nettype wire

### sv/lwks_front.sv
// Front part: accept items, drop out-of-range or unknown ones, queue the rest.
`default_nettype none
module lwks_front #(
	parameter int IN_LEN        = 64,
	parameter int MAX_DIGITS    = 8,
	parameter int MAX_BASE_BITS = 2,
	parameter int OUT_LEN       = 30,
	parameter int OUT_REPS      = 2
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             in_valid,
	output logic            in_ready,
	input  lwks_pkg::item_t in_item,
	output logic            q_push,
	output lwks_pkg::item_t q_item,
	input  wire             q_full
);
	localparam int VEC_WORDS  = OUT_LEN + OUT_REPS;
	localparam int DIGIT_VALS = (1 << MAX_BASE_BITS) - 1;

	logic keep;
	logic hold_q;
	lwks_pkg::item_t item_q;

	always_comb begin
		keep = 1'b0;
		unique case (in_item.operation)
			lwks_pkg::OP_TABLE: keep = (32'(in_item.coeff_index) < IN_LEN)
				&& (32'(in_item.digit_position) < MAX_DIGITS)
				&& (in_item.digit_value != 2'd0)
				&& (32'(in_item.digit_value) <= DIGIT_VALS)
				&& (32'(in_item.word_index) < VEC_WORDS);
			lwks_pkg::OP_BODY:  keep = (32'(in_item.word_index) < OUT_REPS);
			lwks_pkg::OP_COEFF: keep = 1'b1;
			default:            keep = 1'b0;
		endcase
	end

	// One-entry stage: take a new item when none is held or the held one moves on.
	assign in_ready = !hold_q || !q_full;
	assign q_push   = hold_q;
	assign q_item   = item_q;

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) item_q <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= 1'b0;
		end else if (in_ready) begin
			hold_q <= in_valid && keep;
		end
	end
endmodule
`default_nettype wire

### sv/lwks_back.sv
// Back part: table writes, body loads, digit decomposition, subtraction, emission.
`default_nettype none
module lwks_back #(
	parameter int IN_LEN        = 64,
	parameter int MAX_DIGITS    = 8,
	parameter int MAX_BASE_BITS = 2,
	parameter int OUT_LEN       = 30,
	parameter int OUT_REPS      = 2
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire [1:0]       base_bits,
	input  wire [3:0]       digit_count,
	input  wire             q_empty,
	input  lwks_pkg::item_t q_item,
	output logic            q_pop,
	output logic            out_valid,
	input  wire             out_ready,
	output logic [4:0]      out_index,
	output logic [63:0]     out_value,
	output logic            out_last
);
	localparam int VEC_WORDS  = OUT_LEN + OUT_REPS;
	localparam int DIGIT_VALS = (1 << MAX_BASE_BITS) - 1;
	localparam int DEPTH      = IN_LEN * MAX_DIGITS * DIGIT_VALS * VEC_WORDS;
	localparam int AW         = $clog2(DEPTH);
	localparam int IW         = (VEC_WORDS > 1) ? $clog2(VEC_WORDS) : 1;
	localparam int WW         = $clog2(VEC_WORDS + 1);
	localparam int JW         = $clog2(MAX_DIGITS + 1);

	lwks_pkg::back_state_t state_q, state_d;
	logic [63:0]       acc_q [VEC_WORDS];
	logic [63:0]       a_q;
	logic [JW-1:0]     j_q, cnt_q;
	logic [3:0]        bb_q;
	logic [WW-1:0]     w_q;
	logic              rd_s1;
	logic [IW-1:0]     wrd_s1;
	logic [AW-1:0]     vbase_q;
	logic              last_q;
	logic [5:0]        coeff_q;

	logic              we;
	logic [AW-1:0]     waddr, raddr;
	logic [63:0]       rdata;
	logic [MAX_BASE_BITS-1:0] dig;
	logic [7:0]        top;
	logic [3:0]        bb_sat;
	logic [JW-1:0]     cnt_sat;
	logic [7:0]        prod;
	logic              out_fire;

	function automatic logic [AW-1:0] tbase(input logic [5:0] c, input logic [JW-1:0] p,
			input logic [MAX_BASE_BITS-1:0] d);
		logic [63:0] t;
		t = ((64'(c) * 64'(MAX_DIGITS) + 64'(p)) * 64'(DIGIT_VALS) + 64'(d) - 64'd1)
			* 64'(VEC_WORDS);
		return t[AW-1:0];
	endfunction

	lwks_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_table (
		.clk(clk), .we(we), .waddr(waddr), .wdata(q_item.value),
		.raddr(raddr), .rdata(rdata)
	);

	always_comb begin
		bb_sat = (base_bits == 2'd0) ? 4'd1 :
			((32'(base_bits) > MAX_BASE_BITS) ? 4'(MAX_BASE_BITS) : 4'(base_bits));
		cnt_sat = (digit_count == 4'd0) ? JW'(1) :
			((32'(digit_count) > MAX_DIGITS) ? JW'(MAX_DIGITS) : JW'(digit_count));
		prod = 8'(bb_sat) * 8'(cnt_sat);
		top  = (8'(j_q) + 8'd1) * 8'(bb_q);
		dig  = MAX_BASE_BITS'((a_q >> (7'd64 - 7'(top))) & ((64'd1 << bb_q) - 64'd1));
		we    = 1'b0;
		waddr = tbase(q_item.coeff_index, JW'(q_item.digit_position),
			MAX_BASE_BITS'(q_item.digit_value)) + AW'(q_item.word_index);
		raddr = vbase_q + AW'(w_q);
		q_pop = 1'b0;
		state_d = state_q;
		out_fire = out_valid && out_ready;
		unique case (state_q)
			lwks_pkg::ST_IDLE: if (!q_empty) begin
				q_pop = 1'b1;
				if (q_item.operation == lwks_pkg::OP_TABLE) we = 1'b1;
				if (q_item.operation == lwks_pkg::OP_COEFF) state_d = lwks_pkg::ST_DIGIT;
			end
			lwks_pkg::ST_DIGIT: begin
				if (j_q >= cnt_q || top > 8'd64 || 32'(coeff_q) >= IN_LEN)
					state_d = last_q ? lwks_pkg::ST_EMIT : lwks_pkg::ST_IDLE;
				else if (dig != '0) state_d = lwks_pkg::ST_SUB;
			end
			lwks_pkg::ST_SUB: if (!rd_s1 && 32'(w_q) == VEC_WORDS)
				state_d = lwks_pkg::ST_DIGIT;
			lwks_pkg::ST_EMIT: if (out_fire && out_last) state_d = lwks_pkg::ST_IDLE;
			default: state_d = lwks_pkg::ST_IDLE;
		endcase
	end

	assign out_valid = (state_q == lwks_pkg::ST_EMIT);
	assign out_index = 5'(w_q);
	assign out_value = acc_q[IW'(w_q)];
	assign out_last  = (32'(w_q) == VEC_WORDS - 1);

	always_ff @(posedge clk) begin
		if (state_q == lwks_pkg::ST_IDLE && !q_empty) begin
			a_q     <= q_item.value + ((prod >= 8'd64) ? 64'd0 : (64'd1 << (7'd63 - 7'(prod))));
			coeff_q <= q_item.coeff_index;
			last_q  <= q_item.last;
			bb_q    <= bb_sat;
			cnt_q   <= cnt_sat;
		end
		if (state_q == lwks_pkg::ST_DIGIT) vbase_q <= tbase(coeff_q, j_q, dig);
		wrd_s1 <= IW'(w_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lwks_pkg::ST_IDLE;
			j_q     <= '0;
			w_q     <= '0;
			rd_s1   <= 1'b0;
			for (int i = 0; i < VEC_WORDS; i++) acc_q[i] <= '0;
		end else begin
			state_q <= state_d;
			rd_s1   <= (state_q == lwks_pkg::ST_SUB) && (32'(w_q) < VEC_WORDS);
			if (rd_s1) acc_q[wrd_s1] <= acc_q[wrd_s1] - rdata;
			unique case (state_q)
				lwks_pkg::ST_IDLE: begin
					j_q <= '0;
					w_q <= '0;
					if (!q_empty && q_item.operation == lwks_pkg::OP_BODY)
						acc_q[IW'(OUT_LEN) + IW'(q_item.word_index)] <= q_item.value;
				end
				lwks_pkg::ST_DIGIT: begin
					w_q <= '0;
					if (state_d == lwks_pkg::ST_DIGIT) j_q <= j_q + JW'(1);
				end
				lwks_pkg::ST_SUB: begin
					if (32'(w_q) < VEC_WORDS) begin
						w_q <= w_q + WW'(1);
					end else if (!rd_s1) begin
						j_q <= j_q + JW'(1);
					end
				end
				lwks_pkg::ST_EMIT: if (out_fire) begin
					if (32'(w_q) < OUT_LEN) acc_q[IW'(w_q)] <= '0;
					w_q <= out_last ? '0 : w_q + WW'(1);
				end
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

### sv/lwe_key_switch_accumulator.sv
// Top level of the LWE key-switching accumulator.
// An item reaches the back part via the front register and the two-entry queue.
// A coefficient is handled one digit at a time; each nonzero digit reads every
// vector word through the single table read port. Table writes and body loads
// are taken while idle; emission gives one word per cycle when m_axis_tready is
// high. Reset clears control and the accumulator, not the table.
`default_nettype none
module lwe_key_switch_accumulator #(
	parameter int IN_LEN        = 64,
	parameter int MAX_DIGITS    = 8,
	parameter int MAX_BASE_BITS = 2,
	parameter int OUT_LEN       = 30,
	parameter int OUT_REPS      = 2
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire         cfg_index,
	input  wire [3:0]   cfg_data,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	// operation[1:0] coeff_index[7:2] digit_position[10:8] digit_value[12:11]
	// word_index[17:13] value[81:18], zero fill to 88
	input  wire [87:0]  s_axis_tdata,
	input  wire         s_axis_tlast,
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	// out_index[4:0] out_value[68:5], zero fill to 72
	output logic [71:0] m_axis_tdata,
	output logic        m_axis_tlast
);
	logic [1:0] base_bits_q;
	logic [3:0] digit_count_q;
	lwks_pkg::item_t in_item, q_in, q_out;
	logic q_push, q_full, q_pop, q_empty;
	logic [4:0]  o_idx;
	logic [63:0] o_val;

	// Hold configuration; writes must only arrive while idle, which the block does not enforce.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_bits_q   <= 2'd2;
			digit_count_q <= 4'd8;
		end else if (cfg_we) begin
			if (cfg_index == 1'b0) base_bits_q <= cfg_data[1:0];
			else digit_count_q <= cfg_data;
		end
	end

	// Unpack the stream word into item fields.
	always_comb begin
		in_item.operation      = s_axis_tdata[1:0];
		in_item.coeff_index    = s_axis_tdata[7:2];
		in_item.digit_position = s_axis_tdata[10:8];
		in_item.digit_value    = s_axis_tdata[12:11];
		in_item.word_index     = s_axis_tdata[17:13];
		in_item.value          = s_axis_tdata[81:18];
		in_item.last           = s_axis_tlast;
	end

	lwks_front #(.IN_LEN(IN_LEN), .MAX_DIGITS(MAX_DIGITS), .MAX_BASE_BITS(MAX_BASE_BITS),
		.OUT_LEN(OUT_LEN), .OUT_REPS(OUT_REPS)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_item(in_item), .q_push(q_push), .q_item(q_in), .q_full(q_full)
	);

	// Queue decouples classification from the long-running back part.
	lwks_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push(q_push), .push_data(q_in), .full(q_full),
		.pop(q_pop), .pop_data(q_out), .empty(q_empty)
	);

	lwks_back #(.IN_LEN(IN_LEN), .MAX_DIGITS(MAX_DIGITS), .MAX_BASE_BITS(MAX_BASE_BITS),
		.OUT_LEN(OUT_LEN), .OUT_REPS(OUT_REPS)) u_back (
		.clk(clk), .arst_n(arst_n), .base_bits(base_bits_q), .digit_count(digit_count_q),
		.q_empty(q_empty), .q_item(q_out), .q_pop(q_pop),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_index(o_idx), .out_value(o_val), .out_last(m_axis_tlast)
	);

	assign m_axis_tdata = {3'd0, o_val, o_idx};
endmodule
`default_nettype wire
